FILE: rtl/tpts_pkg.sv
// Shared types and constants of the tick priority task scheduler.
// Depends on nothing; used by tpts_ctrl, tpts_dpath and the top level.
package tpts_pkg;

	localparam int TASK_COUNT_DEF = 32;
	localparam int CNT_W          = 8;
	localparam int PRI_W          = 7;
	localparam int TIDX_W         = 5;
	localparam int S_TDATA_W      = 24;
	localparam int M_TDATA_W      = 16;

	// One entry of the task table.
	typedef struct packed {
		logic             present;
		logic [PRI_W-1:0] pri;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TRD,
		ST_TDEC,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_REFILL,
		ST_REFILL_END,
		ST_FRD,
		ST_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic rd_cur;
		logic dec_wr;
		logic scan_init;
		logic scan_rd;
		logic refill_init;
		logic refill_rd;
		logic set_refilled;
		logic commit;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cur_zero;
		logic dec_zero;
		logic scan_last;
		logic pick_zero;
		logic refilled;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/tick_priority_task_scheduler.sv
// Tick priority task scheduler: load one task entry or process a timer tick.
// A tick either decrements the running task's counter or scans the table, and a
// scan that finds no runnable task refills the counters and scans once more. The
// single read port serves the scan, the refill read-modify-write and the final
// counter read one entry a cycle.
// Reset clears the table valid bits, running index and handshake state at once.
//
// Depends on tpts_pkg, tpts_ctrl and tpts_dpath.
//
// Each request on the slave side is either a load (tuser = 1), which writes one
// task entry, or a timer tick (tuser = 0). Every request yields exactly one
// result on the master side. The result register lets the next request be
// accepted while a finished result still waits for m_tready; the controller
// holds a new result back until that register is free.
module tick_priority_task_scheduler #(
	parameter int TASK_COUNT = tpts_pkg::TASK_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, from bit 0 up: task_index[4:0], load_counter[12:5],
	// load_priority[19:13], load_present[20], zero fill [23:21].
	input  logic [tpts_pkg::S_TDATA_W-1:0]  s_tdata,
	// s_tuser: mode[0] (0 = timer tick, 1 = load entry).
	input  logic                            s_tuser,
	// Result channel.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, from bit 0 up: next_task[4:0], switched[5], refilled[6],
	// next_counter[14:7], none_runnable[15].
	output logic [tpts_pkg::M_TDATA_W-1:0]  m_tdata
);

	tpts_pkg::cmd_t  cmd;
	tpts_pkg::stat_t stat;

	// The controller only sequences; all table access and arithmetic sit in the datapath.
	tpts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tpts_dpath #(
		.TASK_COUNT (TASK_COUNT)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.stat     (stat)
	);

endmodule

FILE: rtl/tpts_ctrl.sv
// Sequencing state machine of the tick priority task scheduler.
// Depends on tpts_pkg; drives the command struct of tpts_dpath.
module tpts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            mode,
	output logic            s_tready,
	input  tpts_pkg::stat_t stat,
	output tpts_pkg::cmd_t  cmd
);

	tpts_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			tpts_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = mode ? tpts_pkg::ST_LOAD : tpts_pkg::ST_TRD;
				end
			end
			tpts_pkg::ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = tpts_pkg::ST_FRD;
			end
			tpts_pkg::ST_TRD: begin
				cmd.rd_cur = 1'b1;
				if (stat.cur_zero) begin
					cmd.scan_init = 1'b1;
					state_d       = tpts_pkg::ST_SCAN;
				end else begin
					state_d = tpts_pkg::ST_TDEC;
				end
			end
			tpts_pkg::ST_TDEC: begin
				cmd.dec_wr = 1'b1;
				if (stat.dec_zero) begin
					cmd.scan_init = 1'b1;
					state_d       = tpts_pkg::ST_SCAN;
				end else begin
					state_d = tpts_pkg::ST_FRD;
				end
			end
			tpts_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_d = tpts_pkg::ST_SCAN_END;
				end
			end
			tpts_pkg::ST_SCAN_END: begin
				state_d = tpts_pkg::ST_DECIDE;
			end
			tpts_pkg::ST_DECIDE: begin
				if (!stat.pick_zero || stat.refilled) begin
					cmd.commit = 1'b1;
					state_d    = tpts_pkg::ST_FRD;
				end else begin
					cmd.set_refilled = 1'b1;
					cmd.refill_init  = 1'b1;
					state_d          = tpts_pkg::ST_REFILL;
				end
			end
			tpts_pkg::ST_REFILL: begin
				cmd.refill_rd = 1'b1;
				if (stat.scan_last) begin
					state_d = tpts_pkg::ST_REFILL_END;
				end
			end
			tpts_pkg::ST_REFILL_END: begin
				cmd.scan_init = 1'b1;
				state_d       = tpts_pkg::ST_SCAN;
			end
			tpts_pkg::ST_FRD: begin
				cmd.rd_cur = 1'b1;
				state_d    = tpts_pkg::ST_FIN;
			end
			tpts_pkg::ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = tpts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/tpts_dpath.sv
// Datapath of the tick priority task scheduler: task table memory, scan and
// refill pipeline, running index and result register. Depends on tpts_pkg.
module tpts_dpath #(
	parameter int TASK_COUNT = tpts_pkg::TASK_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tpts_pkg::cmd_t                  cmd,
	input  logic [tpts_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [tpts_pkg::M_TDATA_W-1:0]  m_tdata,
	output tpts_pkg::stat_t                 stat
);

	localparam int IDX_W = $clog2(TASK_COUNT);
	localparam int CW    = tpts_pkg::CNT_W;
	localparam int PW    = tpts_pkg::PRI_W;
	localparam int TW    = tpts_pkg::TIDX_W;

	// Captured request.
	logic [TW-1:0] req_idx_q;
	logic [CW-1:0] req_cnt_q;
	logic [PW-1:0] req_pri_q;
	logic          req_pres_q;

	// Table memory with one valid bit per entry; an entry never written reads as zero.
	tpts_pkg::entry_t mem [TASK_COUNT];
	logic [TASK_COUNT-1:0] valid_q;

	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	tpts_pkg::entry_t rd_ent_s1;
	logic             rd_vld_s1;
	tpts_pkg::entry_t rd_view;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             cmp_s1;
	logic             ref_s1;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	tpts_pkg::entry_t wr_ent;
	logic             load_wr_en;
	logic             ref_wr;
	logic             in_range;

	logic [IDX_W-1:0] scan_addr_q;
	logic [CW-1:0]    best_q;
	logic [IDX_W-1:0] pick_q;
	logic [IDX_W-1:0] running_q;
	logic             sw_q;
	logic             ref_q;
	logic             none_q;

	logic [CW-1:0] dec_cnt;
	logic [CW-1:0] refill_cnt;

	// Result register.
	logic          out_valid_q;
	logic [TW-1:0] out_task_q;
	logic          out_sw_q;
	logic          out_ref_q;
	logic [CW-1:0] out_cnt_q;
	logic          out_none_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_idx_q  <= s_tdata[TW-1:0];
			req_cnt_q  <= s_tdata[TW+CW-1:TW];
			req_pri_q  <= s_tdata[TW+CW+PW-1:TW+CW];
			req_pres_q <= s_tdata[TW+CW+PW];
		end
	end

	assign in_range = (32'(req_idx_q) < TASK_COUNT);
	assign rd_view  = rd_vld_s1 ? rd_ent_s1 : '0;
	assign dec_cnt  = (rd_view.cnt == '0) ? '0 : rd_view.cnt - CW'(1);
	// Half of an 8-bit counter plus a 7-bit priority never exceeds 254, so no clamp is needed.
	assign refill_cnt = CW'(rd_view.cnt >> 1) + CW'(rd_view.pri);

	assign rd_en   = cmd.rd_cur || cmd.scan_rd || cmd.refill_rd;
	assign rd_addr = cmd.rd_cur ? running_q : scan_addr_q;

	assign load_wr_en = cmd.load_wr && in_range;
	assign ref_wr     = ref_s1 && rd_view.present;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = running_q;
		wr_ent  = rd_view;
		if (load_wr_en) begin
			wr_en          = 1'b1;
			wr_addr        = IDX_W'(req_idx_q);
			wr_ent.present = req_pres_q;
			wr_ent.pri     = req_pri_q;
			wr_ent.cnt     = req_cnt_q;
		end else if (cmd.dec_wr) begin
			wr_en      = 1'b1;
			wr_ent.cnt = dec_cnt;
		end else if (ref_wr) begin
			wr_en      = 1'b1;
			wr_addr    = rd_idx_s1;
			wr_ent.cnt = refill_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_ent;
		end
		if (rd_en) begin
			rd_ent_s1 <= mem[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			cmp_s1    <= 1'b0;
			ref_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
			cmp_s1 <= cmd.scan_rd;
			ref_s1 <= cmd.refill_rd;
		end
	end

	// Scan address walks from the top entry down to entry one.
	always_ff @(posedge clk) begin
		if (cmd.scan_init || cmd.refill_init) begin
			scan_addr_q <= IDX_W'(TASK_COUNT - 1);
		end else if (cmd.scan_rd || cmd.refill_rd) begin
			scan_addr_q <= scan_addr_q - IDX_W'(1);
		end
		if (cmd.scan_init) begin
			best_q <= '0;
			pick_q <= '0;
		end else if (cmp_s1 && rd_view.present && (rd_view.cnt > best_q)) begin
			best_q <= rd_view.cnt;
			pick_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			sw_q      <= 1'b0;
			ref_q     <= 1'b0;
			none_q    <= 1'b0;
		end else begin
			if (cmd.capture) begin
				sw_q   <= 1'b0;
				ref_q  <= 1'b0;
				none_q <= 1'b0;
			end
			if (cmd.set_refilled) begin
				ref_q <= 1'b1;
			end
			if (cmd.commit) begin
				running_q <= pick_q;
				sw_q      <= (pick_q != running_q);
				none_q    <= (pick_q == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_task_q <= TW'(running_q);
			out_sw_q   <= sw_q;
			out_ref_q  <= ref_q;
			out_cnt_q  <= rd_view.cnt;
			out_none_q <= none_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_none_q, out_cnt_q, out_ref_q, out_sw_q, out_task_q};

	assign stat.cur_zero  = (running_q == '0);
	assign stat.dec_zero  = (rd_view.cnt <= CW'(1));
	assign stat.scan_last = (scan_addr_q == IDX_W'(1));
	assign stat.pick_zero = (pick_q == '0);
	assign stat.refilled  = ref_q;
	assign stat.out_free  = !out_valid_q || m_tready;

	// The single write port is never claimed by two sources at once.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({load_wr_en, cmd.dec_wr, ref_wr}))
		else $error("table write port claimed twice");

	// Scan compare and refill never share a read slot.
	a_stage_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmp_s1 && ref_s1))
		else $error("scan and refill overlap");

	// The idle task is committed only after a refill has been tried.
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (pick_q == '0) |-> ref_q)
		else $error("idle selected without refill");

	// A result that reports nothing runnable names the idle task and a refill.
	a_none_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !out_none_q || (out_ref_q && (out_task_q == '0)))
		else $error("none_runnable result inconsistent");

endmodule
